// ===== design/mlf_pkg.sv =====
`default_nettype none

package mlf_pkg;

  // widest store address: 256 lines of 128 bytes
  localparam int STORE_ADDR_W = 15;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // input mode codes
  localparam logic [2:0] MODE_BEGIN = 3'd0;
  localparam logic [2:0] MODE_BYTE  = 3'd1;
  localparam logic [2:0] MODE_END   = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // panel command bytes
  localparam logic [7:0] CMD_WRITE    = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h20;
  localparam logic [7:0] BYTE_TRAILER = 8'h00;
  localparam logic [7:0] FILL_RESET   = 8'h00;
  localparam logic [7:0] FILL_CLEAR   = 8'hff;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_BYTE,
    OP_END,
    OP_CLEAR,
    OP_READ
  } op_t;

  // classified command, as the back end carries it out
  typedef struct packed {
    op_t                     op;
    logic [1:0]              n;        // results for this item, 1 to 3
    logic [2:0][7:0]         bytes;    // bytes to send, in order from index 0
    logic                    in_range; // row and column fall inside the panel
    logic                    write_en; // row byte to mirror into the store
    logic                    row_end;  // last byte of the line, closes a row
    logic [7:0]              data;
    logic [STORE_ADDR_W-1:0] addr;
  } cmd_t;

  // bit reversal of one byte
  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/mlf_if.sv =====
`default_nettype none

// command channel
interface mlf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] row;
  logic [5:0] column;
  logic [7:0] data_byte;

  modport source(output valid, mode, row, column, data_byte, input ready);
  modport sink(input valid, mode, row, column, data_byte, output ready);
endinterface

// result channel
interface mlf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [7:0]  read_byte;
  logic [31:0] transfer_total;
  logic [15:0] rows_last_transfer;
  logic [31:0] capture_seq;

  modport source(output valid, out_byte, byte_valid, last, read_byte, transfer_total,
                 rows_last_transfer, capture_seq, input ready);
  modport sink(input valid, out_byte, byte_valid, last, read_byte, transfer_total,
               rows_last_transfer, capture_seq, output ready);
endinterface

`default_nettype wire

// ===== design/mlf_front.sv =====
`default_nettype none

module mlf_front #(
  parameter int LINES      = 240,
  parameter int LINE_BYTES = 50
) (
  mlf_in_if.sink          command,
  input  wire logic       accept_items,
  input  wire logic       q_full,
  output mlf_pkg::cmd_t   cmd,
  output logic            push
);

  localparam int AW = mlf_pkg::STORE_ADDR_W;

  logic       row_ok;
  logic       col_ok;
  logic       first;
  logic       lastb;
  logic       keep;
  logic [7:0] line_addr;

  // position of the byte within the line and the panel
  assign row_ok    = {1'b0, command.row} < 9'(LINES);
  assign col_ok    = {2'b0, command.column} < 8'(LINE_BYTES);
  assign first     = command.column == 6'd0;
  assign lastb     = {2'b0, command.column} == 8'(LINE_BYTES - 1);
  assign line_addr = mlf_pkg::flip8(command.row + 8'd1);

  // classify the item and lay out the bytes it sends
  always_comb begin
    cmd          = '0;
    keep         = 1'b1;
    cmd.in_range = row_ok & col_ok;
    cmd.data     = command.data_byte;
    cmd.addr     = AW'({{(AW-8){1'b0}}, command.row}) * AW'(LINE_BYTES)
                 + AW'({{(AW-6){1'b0}}, command.column});
    unique case (command.mode)
      mlf_pkg::MODE_BEGIN: begin
        cmd.op       = mlf_pkg::OP_BEGIN;
        cmd.n        = 2'd1;
        cmd.bytes[0] = mlf_pkg::CMD_WRITE;
      end
      mlf_pkg::MODE_BYTE: begin
        cmd.op       = mlf_pkg::OP_BYTE;
        cmd.write_en = row_ok & col_ok;
        cmd.row_end  = lastb;
        if (first) begin
          cmd.bytes[0] = line_addr;
          cmd.bytes[1] = command.data_byte;
          cmd.bytes[2] = mlf_pkg::BYTE_TRAILER;
          cmd.n        = lastb ? 2'd3 : 2'd2;
        end else begin
          cmd.bytes[0] = command.data_byte;
          cmd.bytes[1] = mlf_pkg::BYTE_TRAILER;
          cmd.n        = lastb ? 2'd2 : 2'd1;
        end
      end
      mlf_pkg::MODE_END: begin
        cmd.op       = mlf_pkg::OP_END;
        cmd.n        = 2'd1;
        cmd.bytes[0] = mlf_pkg::BYTE_TRAILER;
      end
      mlf_pkg::MODE_CLEAR: begin
        cmd.op       = mlf_pkg::OP_CLEAR;
        cmd.n        = 2'd2;
        cmd.bytes[0] = mlf_pkg::CMD_CLEAR;
        cmd.bytes[1] = mlf_pkg::BYTE_TRAILER;
      end
      mlf_pkg::MODE_READ: begin
        cmd.op       = mlf_pkg::OP_READ;
        cmd.n        = 2'd1;
        cmd.bytes[0] = 8'h00;
      end
      default: begin
        // unused modes are taken and dropped
        keep = 1'b0;
      end
    endcase
  end

  assign command.ready = accept_items & ~q_full;
  assign push          = command.valid & command.ready & keep;

endmodule

`default_nettype wire

// ===== design/mlf_queue.sv =====
`default_nettype none

module mlf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mlf_pkg::cmd_t   push_cmd,
  input  wire logic            pop,
  output mlf_pkg::cmd_t        head,
  output logic                 full,
  output logic                 empty
);

  localparam int PW = $clog2(mlf_pkg::QDEPTH);
  localparam int CW = $clog2(mlf_pkg::QDEPTH + 1);

  mlf_pkg::cmd_t entries [mlf_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(mlf_pkg::QDEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CW'(1);
      end
    end
  end

  // fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mlf_pkg::QDEPTH))
    else $error("queue fill level beyond depth");

endmodule

`default_nettype wire

// ===== design/mlf_back.sv =====
`default_nettype none

module mlf_back #(
  parameter int LINES      = 240,
  parameter int LINE_BYTES = 50
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire mlf_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               accept_items,
  mlf_out_if.source          result
);

  localparam int DEPTH  = LINES * LINE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic              init_busy;
  logic [7:0]        fill_value;
  logic [ADDR_W-1:0] fill_addr;
  mlf_pkg::cmd_t     cur;
  logic [1:0]        idx;
  logic [7:0]        rd_q;
  logic [31:0]       transfer_total;
  logic [31:0]       capture_seq;
  logic [15:0]       rows_current;
  logic [15:0]       rows_last;

  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_byte_valid;
  logic              out_last;
  logic [7:0]        out_read_byte;
  logic [31:0]       out_transfer_total;
  logic [15:0]       out_rows_last;
  logic [31:0]       out_capture_seq;

  logic [7:0]        store [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic              load;
  logic              final_idx;

  assign accept_items = ~init_busy;
  assign q_pop        = (state == ST_IDLE) && !q_empty;
  assign load         = (state == ST_EMIT) && (!out_valid || result.ready);
  assign final_idx    = idx == 2'(cur.n - 2'd1);

  // store port: sweep writes, row byte mirror, capture reads
  assign mem_we    = (state == ST_FILL) || (q_pop && q_head.write_en);
  assign mem_waddr = (state == ST_FILL) ? fill_addr : q_head.addr[ADDR_W-1:0];
  assign mem_wdata = (state == ST_FILL) ? fill_value : q_head.data;
  assign mem_re    = q_pop && (q_head.op == mlf_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store[q_head.addr[ADDR_W-1:0]];
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_FILL;
      init_busy      <= 1'b1;
      fill_value     <= mlf_pkg::FILL_RESET;
      fill_addr      <= '0;
      idx            <= 2'd0;
      transfer_total <= '0;
      capture_seq    <= '0;
      rows_current   <= '0;
      rows_last      <= '0;
    end else begin
      unique case (state)
        ST_FILL: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          if (fill_addr == ADDR_W'(DEPTH - 1)) begin
            fill_addr <= '0;
            if (init_busy) begin
              init_busy <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            idx   <= 2'd0;
            state <= ST_EMIT;
            unique case (q_head.op)
              mlf_pkg::OP_BEGIN: begin
                rows_current <= '0;
              end
              mlf_pkg::OP_BYTE: begin
                if (q_head.row_end) begin
                  rows_current <= rows_current + 16'd1;
                end
              end
              mlf_pkg::OP_END: begin
                rows_last      <= rows_current;
                transfer_total <= transfer_total + 32'd1;
                capture_seq    <= capture_seq + 32'd1;
              end
              mlf_pkg::OP_CLEAR: begin
                rows_current   <= '0;
                rows_last      <= '0;
                transfer_total <= transfer_total + 32'd1;
                capture_seq    <= capture_seq + 32'd1;
                fill_value     <= mlf_pkg::FILL_CLEAR;
                state          <= ST_FILL;
              end
              mlf_pkg::OP_READ: begin
              end
              default: begin
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (load) begin
            idx <= idx + 2'd1;
            if (final_idx) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // held item for the sequencer
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte           <= cur.bytes[idx];
      out_byte_valid     <= cur.op != mlf_pkg::OP_READ;
      out_last           <= final_idx;
      out_read_byte      <= (cur.op == mlf_pkg::OP_READ && cur.in_range) ? rd_q : 8'h00;
      out_transfer_total <= transfer_total;
      out_rows_last      <= rows_last;
      out_capture_seq    <= capture_seq;
    end
  end

  assign result.valid              = out_valid;
  assign result.out_byte           = out_byte;
  assign result.byte_valid         = out_byte_valid;
  assign result.last               = out_last;
  assign result.read_byte          = out_read_byte;
  assign result.transfer_total     = out_transfer_total;
  assign result.rows_last_transfer = out_rows_last;
  assign result.capture_seq        = out_capture_seq;

  // nothing leaves before the start-up sweep is over
  a_quiet_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (!out_valid && state == ST_FILL))
    else $error("result during start-up sweep");

  // the emit index stays inside the item's result list
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (idx < cur.n))
    else $error("emit index past result count");

  // a capture read answers with one result
  a_read_single: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && cur.op == mlf_pkg::OP_READ) |-> (cur.n == 2'd1))
    else $error("read with more than one result");

  // a clear always passes through the sweep before its bytes go out
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.op == mlf_pkg::OP_CLEAR) |=> (state == ST_FILL))
    else $error("clear skipped the store sweep");

endmodule

`default_nettype wire

// ===== design/memory_lcd_line_write_framer.sv =====
// channel   | role   | handshake     | payload
// command   | sink   | valid / ready | mode, row, column, data_byte
// result    | source | valid / ready | out_byte, byte_valid, last, read_byte,
//           |        |               | transfer_total, rows_last_transfer, capture_seq
//
// an item is classified on entry and queued (two entries); the back end pops it
// and then sends its results one a cycle while result.ready allows. a clear also
// sweeps the capture store with 0xff, one byte a cycle, before its results go
// out. after reset the same sweep writes zeros with command.ready low.
// a stalled result holds in the output register while the queue keeps filling.
`default_nettype none

module memory_lcd_line_write_framer #(
  parameter int LINES      = 240,
  parameter int LINE_BYTES = 50
) (
  input  wire logic clk,
  input  wire logic rst,
  mlf_in_if.sink    command,
  mlf_out_if.source result
);

  mlf_pkg::cmd_t push_cmd;
  mlf_pkg::cmd_t q_head;
  logic          push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic          accept_items;

  // front: take and classify items
  mlf_front #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .command      (command),
    .accept_items (accept_items),
    .q_full       (q_full),
    .cmd          (push_cmd),
    .push         (push)
  );

  // queue between the two halves
  mlf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: store, counters and result sequencing
  mlf_back #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .accept_items (accept_items),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sim/tb_memory_lcd_line_write_framer.sv =====
`timescale 1ns / 1ps

module tb_memory_lcd_line_write_framer;

  localparam int LINES       = 240;
  localparam int LINE_BYTES  = 50;
  localparam int STORE_BYTES = LINES * LINE_BYTES;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] row;
    logic [5:0] column;
    logic [7:0] data_byte;
  } lcd_cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [7:0]  read_byte;
    logic [31:0] transfer_total;
    logic [15:0] rows_last_transfer;
    logic [31:0] capture_seq;
  } panel_res_t;

  logic clk;
  logic rst;

  mlf_in_if  cmd_if ();
  mlf_out_if res_if ();

  memory_lcd_line_write_framer #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .command (cmd_if),
    .result  (res_if)
  );

  // commands waiting to be offered, and bytes the panel should receive
  lcd_cmd_t   pending_cmds [$];
  panel_res_t panel_expected [$];

  // shadow of the framer state
  logic [7:0]  capture_shadow [0:STORE_BYTES-1];
  logic [31:0] seq_count;
  logic [31:0] xfer_count;
  logic [15:0] rows_open;
  logic [15:0] rows_done;

  // capture addresses written by the stimulus, packed as {row, column}
  logic [13:0] written_at [$];

  int   err_count;
  int   items_in;
  int   results_seen;
  int   trailers_seen;
  int   clears_seen;
  int   reads_seen;
  int   live_queued;
  int   clears_left;
  int   cycle_count;
  logic in_took;
  logic quiet;

  // no idling on either side for a stretch of the run
  assign quiet = (items_in >= 200) && (items_in < 260);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bit reversal for the line address
  function automatic logic [7:0] mirror_bits8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic panel_res_t send_res(input logic [7:0] b, input logic v,
                                          input logic l, input logic [7:0] rd);
    panel_res_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.read_byte  = rd;
    return r;
  endfunction

  // work out the bytes one command causes and update the shadow state
  task automatic frame_lcd_command(input lcd_cmd_t c);
    panel_res_t r [0:2];
    int         n;
    logic       in_panel;
    int         idx;
    logic [7:0] rd;
    n        = 0;
    in_panel = (c.row < LINES) && (c.column < LINE_BYTES);
    idx      = c.row * LINE_BYTES + c.column;
    case (c.mode)
      mlf_pkg::MODE_BEGIN: begin
        rows_open = '0;
        r[0] = send_res(mlf_pkg::CMD_WRITE, 1'b1, 1'b1, 8'h00);
        n = 1;
      end
      mlf_pkg::MODE_BYTE: begin
        if (in_panel) begin
          capture_shadow[idx] = c.data_byte;
        end
        if (c.column == 0) begin
          r[n] = send_res(mirror_bits8(c.row + 8'd1), 1'b1, 1'b0, 8'h00);
          n = n + 1;
        end
        r[n] = send_res(c.data_byte, 1'b1, c.column != LINE_BYTES - 1, 8'h00);
        n = n + 1;
        if (c.column == LINE_BYTES - 1) begin
          r[n] = send_res(mlf_pkg::BYTE_TRAILER, 1'b1, 1'b1, 8'h00);
          n = n + 1;
          rows_open = rows_open + 16'd1;
          trailers_seen++;
        end
      end
      mlf_pkg::MODE_END: begin
        rows_done  = rows_open;
        xfer_count = xfer_count + 32'd1;
        seq_count  = seq_count + 32'd1;
        r[0] = send_res(mlf_pkg::BYTE_TRAILER, 1'b1, 1'b1, 8'h00);
        n = 1;
      end
      mlf_pkg::MODE_CLEAR: begin
        rows_open  = '0;
        rows_done  = '0;
        xfer_count = xfer_count + 32'd1;
        seq_count  = seq_count + 32'd1;
        for (int i = 0; i < STORE_BYTES; i++) begin
          capture_shadow[i] = mlf_pkg::FILL_CLEAR;
        end
        r[0] = send_res(mlf_pkg::CMD_CLEAR, 1'b1, 1'b0, 8'h00);
        r[1] = send_res(mlf_pkg::BYTE_TRAILER, 1'b1, 1'b1, 8'h00);
        n = 2;
        clears_seen++;
      end
      mlf_pkg::MODE_READ: begin
        rd = in_panel ? capture_shadow[idx] : 8'h00;
        r[0] = send_res(8'h00, 1'b0, 1'b1, rd);
        n = 1;
        reads_seen++;
      end
      default: begin
        // unused modes produce nothing
      end
    endcase
    // counters show the state after the whole command
    for (int k = 0; k < n; k++) begin
      r[k].transfer_total     = xfer_count;
      r[k].rows_last_transfer = rows_done;
      r[k].capture_seq        = seq_count;
      panel_expected.push_back(r[k]);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, got_v);
      end
    end
  endtask

  // compare one result with the oldest expected one
  task automatic check_result();
    panel_res_t e;
    results_seen++;
    if (panel_expected.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS) begin
        $display("%0t: unexpected result, expected none, got byte %0h", $time,
                 res_if.out_byte);
      end
    end else begin
      e = panel_expected.pop_front();
      check_field("out_byte", e.out_byte, res_if.out_byte);
      check_field("byte_valid", e.byte_valid, res_if.byte_valid);
      check_field("last", e.last, res_if.last);
      check_field("read_byte", e.read_byte, res_if.read_byte);
      check_field("transfer_total", e.transfer_total, res_if.transfer_total);
      check_field("rows_last_transfer", e.rows_last_transfer, res_if.rows_last_transfer);
      check_field("capture_seq", e.capture_seq, res_if.capture_seq);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= cmd_if.valid && cmd_if.ready;
      if (res_if.valid && res_if.ready) begin
        check_result();
      end
      if (cmd_if.valid && cmd_if.ready) begin
        frame_lcd_command({cmd_if.mode, cmd_if.row, cmd_if.column, cmd_if.data_byte});
        items_in <= items_in + 1;
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    lcd_cmd_t c;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || in_took) begin
      if (pending_cmds.size() > 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
        c = pending_cmds.pop_front();
        cmd_if.valid     <= 1'b1;
        cmd_if.mode      <= c.mode;
        cmd_if.row       <= c.row;
        cmd_if.column    <= c.column;
        cmd_if.data_byte <= c.data_byte;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off while commands keep coming
  always @(negedge clk) begin
    int   hold_left;
    logic hold_done;
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && items_in >= 120) begin
      res_if.ready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      res_if.ready <= quiet || ($urandom_range(0, 99) >= 23);
    end
  end

  task automatic queue_cmd(input logic [2:0] mode, input logic [7:0] row,
                           input logic [5:0] column, input logic [7:0] data_byte);
    pending_cmds.push_back({mode, row, column, data_byte});
    if (mode <= mlf_pkg::MODE_READ) begin
      live_queued++;
    end
    if (mode == mlf_pkg::MODE_BYTE && row < LINES && column < LINE_BYTES) begin
      written_at.push_back({row, column});
    end
  endtask

  // read back a captured byte, or a random spot now and then or if nothing was written yet
  task automatic queue_readback();
    logic [13:0] a;
    if (written_at.size() > 0 && $urandom_range(0, 3) != 0) begin
      a = written_at[$urandom_range(0, written_at.size() - 1)];
      queue_cmd(mlf_pkg::MODE_READ, a[13:6], a[5:0], 8'($urandom));
    end else begin
      queue_cmd(mlf_pkg::MODE_READ, 8'($urandom), 6'($urandom), 8'($urandom));
    end
  endtask

  // one well-formed write: begin, a few lines, end, then at times a clear and a readback
  task automatic queue_frame();
    int         lines_n;
    int         cols_n;
    logic [7:0] row;
    logic [5:0] col;
    queue_cmd(mlf_pkg::MODE_BEGIN, 8'($urandom), 6'($urandom), 8'($urandom));
    lines_n = $urandom_range(1, 3);
    for (int l = 0; l < lines_n; l++) begin
      if ($urandom_range(0, 9) == 0) begin
        row = 8'($urandom_range(LINES, 255));
      end else begin
        row = 8'($urandom_range(0, LINES - 1));
      end
      queue_cmd(mlf_pkg::MODE_BYTE, row, 6'd0, 8'($urandom));
      cols_n = $urandom_range(0, 4);
      for (int k = 0; k < cols_n; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          col = 6'($urandom_range(LINE_BYTES, 63));
        end else begin
          col = 6'($urandom_range(1, LINE_BYTES - 2));
        end
        queue_cmd(mlf_pkg::MODE_BYTE, row, col, 8'($urandom));
      end
      if ($urandom_range(0, 4) != 0) begin
        queue_cmd(mlf_pkg::MODE_BYTE, row, 6'(LINE_BYTES - 1), 8'($urandom));
      end
      if ($urandom_range(0, 1) == 1) begin
        queue_readback();
      end
    end
    queue_cmd(mlf_pkg::MODE_END, 8'($urandom), 6'($urandom), 8'($urandom));
    if (clears_left > 0 && $urandom_range(0, 29) == 0) begin
      clears_left--;
      queue_cmd(mlf_pkg::MODE_CLEAR, 8'($urandom), 6'($urandom), 8'($urandom));
      queue_readback();
    end
  endtask

  // loose commands with any field values, modes out of order included
  task automatic queue_noise();
    logic [2:0] mode;
    int         cnt;
    cnt = $urandom_range(1, 3);
    for (int k = 0; k < cnt; k++) begin
      mode = 3'($urandom_range(0, 7));
      if (mode == mlf_pkg::MODE_CLEAR) begin
        if (clears_left > 0) begin
          clears_left--;
        end else begin
          mode = mlf_pkg::MODE_READ;
        end
      end
      queue_cmd(mode, 8'($urandom), 6'($urandom), 8'($urandom));
    end
  endtask

  task automatic queue_random_phase(input int target);
    int start;
    start = live_queued;
    while (live_queued - start < target) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_frame();
      end else begin
        queue_noise();
      end
    end
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_cmds.size() != 0 || panel_expected.size() != 0 || cmd_if.valid);
  endtask

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cmd_if.valid        = 1'b0;
    cmd_if.mode         = mlf_pkg::MODE_BEGIN;
    cmd_if.row          = '0;
    cmd_if.column       = '0;
    cmd_if.data_byte    = '0;
    res_if.ready        = 1'b0;
    err_count           = 0;
    items_in            = 0;
    results_seen        = 0;
    trailers_seen       = 0;
    clears_seen         = 0;
    reads_seen          = 0;
    live_queued         = 0;
    clears_left         = 3;
    cycle_count         = 0;
    seq_count           = '0;
    xfer_count          = '0;
    rows_open           = '0;
    rows_done           = '0;
    for (int i = 0; i < STORE_BYTES; i++) begin
      capture_shadow[i] = mlf_pkg::FILL_RESET;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: line edges, panel edges, address wrap, unused modes, clear
    @(posedge clk);
    queue_cmd(mlf_pkg::MODE_READ, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_BEGIN, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd0, 6'd1, 8'hff);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd0, 6'(LINE_BYTES - 1), 8'ha5);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'(LINES - 1), 6'd0, 8'h5a);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'(LINES - 1), 6'(LINE_BYTES - 1), 8'h3c);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'(LINES), 6'd0, 8'h11);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd255, 6'd0, 8'h22);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd255, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd255, 6'(LINE_BYTES - 1), 8'h44);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd7, 6'(LINE_BYTES), 8'h33);
    queue_cmd(mlf_pkg::MODE_BYTE, 8'd7, 6'd63, 8'hcc);
    queue_cmd(mlf_pkg::MODE_END, 8'hff, 6'd63, 8'hff);
    queue_cmd(mlf_pkg::MODE_READ, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_READ, 8'(LINES - 1), 6'(LINE_BYTES - 1), 8'h00);
    queue_cmd(mlf_pkg::MODE_READ, 8'(LINES), 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_READ, 8'd0, 6'(LINE_BYTES), 8'h00);
    queue_cmd(mlf_pkg::MODE_READ, 8'd255, 6'd63, 8'hff);
    queue_cmd(3'd5, 8'd1, 6'd1, 8'h01);
    queue_cmd(3'd6, 8'd2, 6'd2, 8'h02);
    queue_cmd(3'd7, 8'hff, 6'd63, 8'hff);
    queue_cmd(mlf_pkg::MODE_END, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_CLEAR, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_READ, 8'd0, 6'd0, 8'h00);
    queue_cmd(mlf_pkg::MODE_BEGIN, 8'd0, 6'd0, 8'h00);
    wait_drained();

    // random frames and noise, in two phases with a full drain between
    @(posedge clk);
    queue_random_phase(140);
    wait_drained();
    @(posedge clk);
    queue_random_phase(140);
    wait_drained();

    // let any ignored command or stray result come out
    repeat (100) @(negedge clk);

    $display("Run: %0d commands in, %0d results out, %0d full lines, %0d clears, %0d reads",
             items_in, results_seen, trailers_seen, clears_seen, reads_seen);
    if (panel_expected.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, panel_expected.size());
    end
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
